// ----- design/lavb_pkg.sv -----
`default_nettype none

package lavb_pkg;

  localparam int unsigned SqrtSteps = 31;
  localparam int unsigned DivSteps  = 31;

  localparam logic [1:0] AXIS_SIDE    = 2'd0;
  localparam logic [1:0] AXIS_UP      = 2'd1;
  localparam logic [1:0] AXIS_FORWARD = 2'd2;

  localparam logic [2:0] REG_LEFT_HANDED = 3'd0;

  localparam logic signed [34:0] OneQ30   = 35'sd1073741824;
  localparam logic signed [34:0] MaxInt32 = 35'sd2147483647;
  localparam logic signed [34:0] MinInt32 = -35'sd2147483648;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][31:0] up;
    logic [2:0][31:0] fw;
    logic             deg;
  } side_t;

  function automatic logic signed [34:0] rnd30(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] sum;
    logic [34:0] q;
    mag = v[63] ? 64'(-v) : 64'(v);
    sum = mag + 64'h2000_0000;
    q = {1'b0, sum[63:30]};
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

endpackage

`default_nettype wire

// ----- design/lavb_norm.sv -----
`default_nettype none

module lavb_norm import lavb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [2:0][63:0] vec,
  input  side_t            in_side,
  output logic             out_valid,
  output logic [2:0][31:0] unit,
  output logic             zero,
  output side_t            out_side
);

  typedef struct packed {
    logic [2:0][29:0] m;
    logic [2:0]       neg;
    logic             zero;
    side_t            side;
  } nrm_t;

  typedef struct packed {
    logic [30:0]      l;
    logic [2:0][30:0] rem;
    logic [2:0][30:0] lo;
    logic [2:0][30:0] q;
    logic [2:0]       neg;
    logic             zero;
    side_t            side;
  } dv_t;

  logic             a_v;
  logic [2:0][63:0] a_m;
  logic [2:0]       a_neg;
  side_t            a_side;
  logic [63:0]      a_or;

  logic             b_v;
  logic [2:0][63:0] b_m;
  logic [2:0]       b_neg;
  side_t            b_side;
  logic [7:0]       b_nz;
  logic [7:0][2:0]  b_pos;
  logic [7:0]       nz_next;
  logic [7:0][2:0]  pos_next;

  logic             c_v;
  logic [2:0][63:0] c_m;
  logic [2:0]       c_neg;
  side_t            c_side;
  logic [5:0]       c_p;
  logic             c_zero;
  logic [5:0]       p_next;

  logic             d_v;
  logic [2:0][29:0] d_m;
  logic [2:0]       d_neg;
  side_t            d_side;
  logic             d_zero;

  logic             e_v;
  logic [2:0][29:0] e_m;
  logic [2:0]       e_neg;
  side_t            e_side;
  logic             e_zero;
  logic [2:0][59:0] e_sq;

  logic [SqrtSteps:0]       sq_v;
  logic [SqrtSteps:0][61:0] sq_n;
  logic [SqrtSteps:0][61:0] sq_r;
  nrm_t                     sq_p [SqrtSteps+1];

  logic [DivSteps:0] dv_v;
  dv_t               dv_p [DivSteps+1];

  assign a_or = a_m[0] | a_m[1] | a_m[2];

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      nz_next[j] = |a_or[8*j +: 8];
      pos_next[j] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (a_or[8*j+b]) begin
          pos_next[j] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    p_next = 6'd0;
    for (int j = 0; j < 8; j++) begin
      if (b_nz[j]) begin
        p_next = {3'(j), b_pos[j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
      sq_v[0] <= 1'b0;
    end else begin
      a_v <= in_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      e_v <= d_v;
      sq_v[0] <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a_m[i] <= vec[i][63] ? 64'(-$signed(vec[i])) : vec[i];
      a_neg[i] <= vec[i][63];
    end
    a_side <= in_side;
    b_m <= a_m;
    b_neg <= a_neg;
    b_side <= a_side;
    b_nz <= nz_next;
    b_pos <= pos_next;
    c_m <= b_m;
    c_neg <= b_neg;
    c_side <= b_side;
    c_p <= p_next;
    c_zero <= ~|b_nz;
    for (int i = 0; i < 3; i++) begin
      if (c_p >= 6'd29) begin
        d_m[i] <= 30'(c_m[i] >> (c_p - 6'd29));
      end else begin
        d_m[i] <= 30'(c_m[i] << (6'd29 - c_p));
      end
    end
    d_neg <= c_neg;
    d_side <= c_side;
    d_zero <= c_zero;
    for (int i = 0; i < 3; i++) begin
      e_sq[i] <= d_m[i] * d_m[i];
    end
    e_m <= d_m;
    e_neg <= d_neg;
    e_side <= d_side;
    e_zero <= d_zero;
    sq_n[0] <= 62'(e_sq[0]) + 62'(e_sq[1]) + 62'(e_sq[2]);
    sq_r[0] <= 62'd0;
    sq_p[0] <= '{m: e_m, neg: e_neg, zero: e_zero, side: e_side};
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    localparam logic [61:0] Bit = 62'd1 << (2 * (SqrtSteps - 1 - k));
    logic [61:0] trial;
    assign trial = sq_r[k] + Bit;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (sq_n[k] >= trial) begin
        sq_n[k+1] <= sq_n[k] - trial;
        sq_r[k+1] <= (sq_r[k] >> 1) + Bit;
      end else begin
        sq_n[k+1] <= sq_n[k];
        sq_r[k+1] <= sq_r[k] >> 1;
      end
      sq_p[k+1] <= sq_p[k];
    end
  end

  logic [30:0]      root;
  logic [2:0][60:0] dividend;
  nrm_t             sq_last;

  assign root = sq_r[SqrtSteps][30:0];
  assign sq_last = sq_p[SqrtSteps];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dividend[i] = {1'b0, sq_last.m[i], 30'd0} + 61'(root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= sq_v[SqrtSteps];
    end
  end

  always_ff @(posedge clk) begin
    dv_p[0].l <= root;
    for (int i = 0; i < 3; i++) begin
      dv_p[0].rem[i] <= {1'b0, dividend[i][60:31]};
      dv_p[0].lo[i] <= dividend[i][30:0];
      dv_p[0].q[i] <= 31'd0;
    end
    dv_p[0].neg <= sq_last.neg;
    dv_p[0].zero <= sq_last.zero;
    dv_p[0].side <= sq_last.side;
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic [2:0][31:0] t;
    logic [2:0]       ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i] = {dv_p[j].rem[i], dv_p[j].lo[i][30]};
        ge[i] = t[i] >= {1'b0, dv_p[j].l};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      dv_p[j+1].l <= dv_p[j].l;
      for (int i = 0; i < 3; i++) begin
        dv_p[j+1].rem[i] <= ge[i] ? 31'(t[i] - {1'b0, dv_p[j].l}) : t[i][30:0];
        dv_p[j+1].lo[i] <= dv_p[j].lo[i] << 1;
        dv_p[j+1].q[i] <= {dv_p[j].q[i][29:0], ge[i]};
      end
      dv_p[j+1].neg <= dv_p[j].neg;
      dv_p[j+1].zero <= dv_p[j].zero;
      dv_p[j+1].side <= dv_p[j].side;
    end
  end

  dv_t         dv_last;
  logic [2:0][31:0] qc;

  assign dv_last = dv_p[DivSteps];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_last.q[i] > 31'h4000_0000) ? 32'h4000_0000 : {1'b0, dv_last.q[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_v[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      unit[i] <= dv_last.neg[i] ? 32'(-$signed(qc[i])) : qc[i];
    end
    zero <= dv_last.zero;
    out_side <= dv_last.side;
  end

endmodule

`default_nettype wire

// ----- design/lavb_tail.sv -----
`default_nettype none

module lavb_tail import lavb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [2:0][31:0]    sd,
  input  logic                zero,
  input  side_t               in_side,
  output logic                done,
  output logic [1:0]          axis_index,
  output logic signed [31:0]  axis_x,
  output logic signed [31:0]  axis_y,
  output logic signed [31:0]  axis_z,
  output logic signed [31:0]  translation,
  output logic                degenerate,
  output logic                last
);

  logic                    t1_v;
  logic signed [2:0][63:0] t1_pa;
  logic signed [2:0][63:0] t1_pb;
  logic [2:0][31:0]        t1_sd;
  logic [2:0][31:0]        t1_fw;
  logic [2:0][31:0]        t1_eye;
  logic                    t1_ok;

  logic                    t2_v;
  logic signed [2:0][63:0] t2_c;
  logic [2:0][31:0]        t2_sd;
  logic [2:0][31:0]        t2_fw;
  logic [2:0][31:0]        t2_eye;
  logic                    t2_ok;

  logic                    t3_v;
  logic [2:0][2:0][31:0]   t3_ax;
  logic [2:0][31:0]        t3_eye;
  logic                    t3_ok;
  logic signed [2:0][34:0] up_r;

  logic                    t4_v;
  logic [2:0][2:0][31:0]   t4_ax;
  logic signed [2:0][2:0][63:0] t4_p;
  logic                    t4_ok;

  logic                    t5_v;
  logic [2:0][2:0][31:0]   t5_ax;
  logic signed [2:0][63:0] t5_dot;
  logic                    t5_ok;

  logic                    t6_v;
  logic [2:0][2:0][31:0]   t6_ax;
  logic [2:0][31:0]        t6_tr;
  logic                    t6_deg;
  logic signed [2:0][34:0] tneg;

  logic [1:0]              phase;
  logic [2:0][31:0]        buf1_ax;
  logic [31:0]             buf1_tr;
  logic [2:0][31:0]        buf2_ax;
  logic [31:0]             buf2_tr;
  logic                    buf_deg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up_r[i] = rnd30(t2_c[i]);
    end
    for (int k = 0; k < 3; k++) begin
      tneg[k] = -rnd30(t5_dot[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
      t2_v <= 1'b0;
      t3_v <= 1'b0;
      t4_v <= 1'b0;
      t5_v <= 1'b0;
      t6_v <= 1'b0;
    end else begin
      t1_v <= in_valid;
      t2_v <= t1_v;
      t3_v <= t2_v;
      t4_v <= t3_v;
      t5_v <= t4_v;
      t6_v <= t5_v;
    end
  end

  always_ff @(posedge clk) begin
    t1_pa[0] <= $signed(in_side.fw[1]) * $signed(sd[2]);
    t1_pb[0] <= $signed(in_side.fw[2]) * $signed(sd[1]);
    t1_pa[1] <= $signed(in_side.fw[2]) * $signed(sd[0]);
    t1_pb[1] <= $signed(in_side.fw[0]) * $signed(sd[2]);
    t1_pa[2] <= $signed(in_side.fw[0]) * $signed(sd[1]);
    t1_pb[2] <= $signed(in_side.fw[1]) * $signed(sd[0]);
    t1_sd <= sd;
    t1_fw <= in_side.fw;
    t1_eye <= in_side.eye;
    t1_ok <= !in_side.deg && !zero;

    for (int i = 0; i < 3; i++) begin
      t2_c[i] <= t1_pa[i] - t1_pb[i];
    end
    t2_sd <= t1_sd;
    t2_fw <= t1_fw;
    t2_eye <= t1_eye;
    t2_ok <= t1_ok;

    t3_ax[AXIS_SIDE] <= t2_sd;
    t3_ax[AXIS_FORWARD] <= t2_fw;
    for (int i = 0; i < 3; i++) begin
      if ($signed(up_r[i]) > OneQ30) begin
        t3_ax[AXIS_UP][i] <= 32'h4000_0000;
      end else if ($signed(up_r[i]) < -OneQ30) begin
        t3_ax[AXIS_UP][i] <= 32'hC000_0000;
      end else begin
        t3_ax[AXIS_UP][i] <= up_r[i][31:0];
      end
    end
    t3_eye <= t2_eye;
    t3_ok <= t2_ok;

    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        t4_p[k][i] <= $signed(t3_ax[k][i]) * $signed(t3_eye[i]);
      end
    end
    t4_ax <= t3_ax;
    t4_ok <= t3_ok;

    for (int k = 0; k < 3; k++) begin
      t5_dot[k] <= t4_p[k][0] + t4_p[k][1] + t4_p[k][2];
    end
    t5_ax <= t4_ax;
    t5_ok <= t4_ok;

    for (int k = 0; k < 3; k++) begin
      if (!t5_ok) begin
        t6_tr[k] <= 32'd0;
      end else if ($signed(tneg[k]) > MaxInt32) begin
        t6_tr[k] <= 32'h7FFF_FFFF;
      end else if ($signed(tneg[k]) < MinInt32) begin
        t6_tr[k] <= 32'h8000_0000;
      end else begin
        t6_tr[k] <= tneg[k][31:0];
      end
    end
    t6_ax <= t5_ok ? t5_ax : '0;
    t6_deg <= !t5_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      phase <= 2'd0;
    end else begin
      done <= 1'b0;
      if (t6_v) begin
        done <= 1'b1;
        phase <= 2'd1;
      end else if (phase != 2'd0) begin
        done <= 1'b1;
        phase <= (phase == 2'd2) ? 2'd0 : phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (t6_v) begin
      axis_index <= AXIS_SIDE;
      axis_x <= t6_ax[AXIS_SIDE][0];
      axis_y <= t6_ax[AXIS_SIDE][1];
      axis_z <= t6_ax[AXIS_SIDE][2];
      translation <= t6_tr[AXIS_SIDE];
      degenerate <= t6_deg;
      last <= 1'b0;
      buf1_ax <= t6_ax[AXIS_UP];
      buf1_tr <= t6_tr[AXIS_UP];
      buf2_ax <= t6_ax[AXIS_FORWARD];
      buf2_tr <= t6_tr[AXIS_FORWARD];
      buf_deg <= t6_deg;
    end else if (phase != 2'd0) begin
      axis_index <= (phase == 2'd2) ? AXIS_FORWARD : AXIS_UP;
      axis_x <= buf1_ax[0];
      axis_y <= buf1_ax[1];
      axis_z <= buf1_ax[2];
      translation <= buf1_tr;
      degenerate <= buf_deg;
      last <= (phase == 2'd2);
      buf1_ax <= buf2_ax;
      buf1_tr <= buf2_tr;
    end
  end

endmodule

`default_nettype wire

// ----- design/look_at_view_basis_unit.sv -----
`default_nettype none

// Builds the side, up and forward axes of a look-at camera from an eye point, a target
// point and an up vector, all signed Q16.16, with each axis's negated dot product with
// the eye. A transaction is taken when start is high and busy is low; busy is then held
// high by a down-counter, which spaces transactions to match the result cycles on the
// output side, and a new transaction can be taken while earlier ones are still in flight.
// Results appear on consecutive cycles marked by done, in the order side, up, forward;
// they cannot be held off and must be captured when done is high. The pipeline depth
// comes from two normalizers, each a pipelined square root and divider that resolve one
// bit per stage.

module look_at_view_basis_unit import lavb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] up_x,
  input  logic signed [31:0] up_y,
  input  logic signed [31:0] up_z,
  output logic               done,
  output logic [1:0]         axis_index,
  output logic signed [31:0] axis_x,
  output logic signed [31:0] axis_y,
  output logic signed [31:0] axis_z,
  output logic signed [31:0] translation,
  output logic               degenerate,
  output logic               last
);

  logic             left_handed;
  logic [1:0]       hold;
  logic             accept;

  logic             f_v;
  logic [2:0][63:0] f_d;
  side_t            f_side;
  logic [2:0][31:0] eye_v;
  logic [2:0][31:0] tgt_v;
  logic [2:0][31:0] up_v;
  logic [2:0][32:0] diff;

  logic             n1_v;
  logic [2:0][31:0] n1_unit;
  logic             n1_zero;
  side_t            n1_side;

  logic                    x1_v;
  logic signed [2:0][63:0] x1_pa;
  logic signed [2:0][63:0] x1_pb;
  side_t                   x1_side;

  logic             x2_v;
  logic [2:0][63:0] x2_c;
  side_t            x2_side;

  logic             n2_v;
  logic [2:0][31:0] n2_unit;
  logic             n2_zero;
  side_t            n2_side;

  assign pready = 1'b1;
  assign accept = start && !busy;
  assign busy = hold != 2'd0;
  assign prdata = (paddr[2] == REG_LEFT_HANDED[0]) ? {31'd0, left_handed} : 32'd0;

  assign eye_v = {eye_z, eye_y, eye_x};
  assign tgt_v = {target_z, target_y, target_x};
  assign up_v = {up_z, up_y, up_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (left_handed) begin
        diff[i] = 33'($signed(tgt_v[i])) - 33'($signed(eye_v[i]));
      end else begin
        diff[i] = 33'($signed(eye_v[i])) - 33'($signed(tgt_v[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_handed <= 1'b0;
      hold <= 2'd0;
      f_v <= 1'b0;
      x1_v <= 1'b0;
      x2_v <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_LEFT_HANDED[0]) begin
        left_handed <= pwdata[0];
      end
      if (accept) begin
        hold <= 2'd2;
      end else if (hold != 2'd0) begin
        hold <= hold - 2'd1;
      end
      f_v <= accept;
      x1_v <= n1_v;
      x2_v <= x1_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      f_d[i] <= 64'($signed(diff[i]));
    end
    f_side <= '{eye: eye_v, up: up_v, fw: '0, deg: 1'b0};

    x1_pa[0] <= $signed(n1_side.up[1]) * $signed(n1_unit[2]);
    x1_pb[0] <= $signed(n1_side.up[2]) * $signed(n1_unit[1]);
    x1_pa[1] <= $signed(n1_side.up[2]) * $signed(n1_unit[0]);
    x1_pb[1] <= $signed(n1_side.up[0]) * $signed(n1_unit[2]);
    x1_pa[2] <= $signed(n1_side.up[0]) * $signed(n1_unit[1]);
    x1_pb[2] <= $signed(n1_side.up[1]) * $signed(n1_unit[0]);
    x1_side <= '{eye: n1_side.eye, up: n1_side.up, fw: n1_unit, deg: n1_zero};

    for (int i = 0; i < 3; i++) begin
      x2_c[i] <= x1_pa[i] - x1_pb[i];
    end
    x2_side <= x1_side;
  end

  lavb_norm u_norm_fw (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_v),
    .vec      (f_d),
    .in_side  (f_side),
    .out_valid(n1_v),
    .unit     (n1_unit),
    .zero     (n1_zero),
    .out_side (n1_side)
  );

  lavb_norm u_norm_sd (
    .clk      (clk),
    .rst      (rst),
    .in_valid (x2_v),
    .vec      (x2_c),
    .in_side  (x2_side),
    .out_valid(n2_v),
    .unit     (n2_unit),
    .zero     (n2_zero),
    .out_side (n2_side)
  );

  lavb_tail u_tail (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (n2_v),
    .sd         (n2_unit),
    .zero       (n2_zero),
    .in_side    (n2_side),
    .done       (done),
    .axis_index (axis_index),
    .axis_x     (axis_x),
    .axis_y     (axis_y),
    .axis_z     (axis_z),
    .translation(translation),
    .degenerate (degenerate),
    .last       (last)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy ##1 busy ##1 !busy)
    else $error("busy window after a transaction is wrong");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> axis_x == 0 && axis_y == 0 && axis_z == 0 && translation == 0)
    else $error("degenerate result carries nonzero data");

  a_last_forward: assert property (@(posedge clk) disable iff (rst)
    done |-> last == (axis_index == AXIS_FORWARD))
    else $error("last does not mark the forward axis");

  a_triplet: assert property (@(posedge clk) disable iff (rst)
    done && axis_index == AXIS_SIDE |=> done && axis_index == AXIS_UP)
    else $error("up axis does not follow side axis");
`endif

endmodule

`default_nettype wire
